FILE: rtl/crd_pkg.sv
package crd_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int QUAT_W     = 16;
    localparam int PLANE_W    = 16;
    localparam int STEP_W     = 32;
    localparam int DIR_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // pixel times step, then offset magnitude
    localparam int PROD_W = COL_W + STEP_W;
    // camera-space vector, Q.28 with sign
    localparam int P_FRAC = 28;
    localparam int P_W    = P_FRAC + 1;
    // rotated vector: sum and magnitude
    localparam int R_W  = 66;
    localparam int RM_W = R_W - 1;
    // the largest normalised magnitude lies in [2^29, 2^30)
    localparam int N_TOP = 29;
    localparam int N_W   = N_TOP + 1;
    localparam int SQ_W  = 2 * N_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int DQ_W   = DIR_W;
    localparam int NUM_W  = N_W + DQ_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W       = 8'd0,
        REG_QUAT_X       = 8'd1,
        REG_QUAT_Y       = 8'd2,
        REG_QUAT_Z       = 8'd3,
        REG_PLANE_WIDTH  = 8'd4,
        REG_PLANE_HEIGHT = 8'd5,
        REG_STEP_H       = 8'd6,
        REG_STEP_V       = 8'd7
    } reg_idx_t;

    typedef logic [2:0][P_W-1:0]  pvec_t;
    typedef logic [2:0][RM_W-1:0] rmag_t;

    typedef struct packed {
        logic [2:0][N_W-1:0] mag;
        logic [2:0]          neg;
        logic                zero;
    } norm_t;

    typedef struct packed {
        logic [QUAT_W-1:0] w;
        logic [QUAT_W-1:0] x;
        logic [QUAT_W-1:0] y;
        logic [QUAT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane_width;
        logic [PLANE_W-1:0] plane_height;
        logic [STEP_W-1:0]  step_h;
        logic [STEP_W-1:0]  step_v;
    } view_t;

endpackage

FILE: rtl/crd_map.sv
module crd_map
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [crd_pkg::COL_W-1:0]   col,
    input  logic [crd_pkg::ROW_W-1:0]   row,
    input  crd_pkg::view_t              view,
    output logic                        out_valid,
    output crd_pkg::pvec_t              p
);

    localparam int PW = crd_pkg::PROD_W;
    localparam logic [16:0] COL_LIM = 17'(crd_pkg::MAX_COLUMNS - 1);
    localparam logic [16:0] ROW_LIM = 17'(crd_pkg::MAX_ROWS - 1);

    logic [3:0] vld_reg;

    logic [crd_pkg::COL_W-1:0] col_c;
    logic [crd_pkg::ROW_W-1:0] row_c;
    logic [PW-1:0] prod_h_reg, prod_v_reg;

    logic signed [PW:0] h_s, v_s;
    logic [PW-1:0] mag_h_reg, mag_v_reg;
    logic          neg_h_reg, neg_v_reg;

    logic [PW-1:0] orv;
    logic [5:0]    blen;
    logic [4:0]    sh_next, sh_reg;
    logic [PW-1:0] mag_h3_reg, mag_v3_reg;
    logic          neg_h3_reg, neg_v3_reg;

    logic [PW-1:0] sh_h, sh_v;
    crd_pkg::pvec_t p_next, p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // clamp to the frame, then scale by the step
    always_comb
    begin
        col_c = ({5'd0, col} > COL_LIM) ? COL_LIM[crd_pkg::COL_W-1:0] : col;
        row_c = ({5'd0, row} > ROW_LIM) ? ROW_LIM[crd_pkg::ROW_W-1:0] : row;
    end

    always_comb
    begin
        h_s = $signed({1'b0, prod_h_reg}) - $signed({13'd0, view.plane_width, 15'd0});
        v_s = $signed({1'b0, prod_v_reg}) - $signed({13'd0, view.plane_height, 15'd0});
    end

    // shift count that brings every magnitude, the unit axis included, below 2^28
    always_comb
    begin
        orv  = mag_h_reg | mag_v_reg;
        blen = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (orv[i])
            begin
                blen = 6'(i + 1);
            end
        end
        sh_next = (blen > 6'(crd_pkg::P_FRAC + 1)) ? 5'(blen - 6'(crd_pkg::P_FRAC)) : 5'd1;
    end

    always_comb
    begin
        sh_h = mag_h3_reg >> sh_reg;
        sh_v = mag_v3_reg >> sh_reg;
        p_next[0] = (crd_pkg::P_W'(1) << crd_pkg::P_FRAC) >> sh_reg;
        p_next[1] = neg_h3_reg ? crd_pkg::P_W'(-{1'b0, sh_h[crd_pkg::P_FRAC-1:0]})
                               : {1'b0, sh_h[crd_pkg::P_FRAC-1:0]};
        p_next[2] = neg_v3_reg ? crd_pkg::P_W'(-{1'b0, sh_v[crd_pkg::P_FRAC-1:0]})
                               : {1'b0, sh_v[crd_pkg::P_FRAC-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_h_reg <= PW'(col_c) * PW'(view.step_h);
            prod_v_reg <= PW'(row_c) * PW'(view.step_v);

            neg_h_reg <= h_s[PW];
            neg_v_reg <= v_s[PW];
            mag_h_reg <= h_s[PW] ? PW'(-h_s) : PW'(h_s);
            mag_v_reg <= v_s[PW] ? PW'(-v_s) : PW'(v_s);

            sh_reg     <= sh_next;
            mag_h3_reg <= mag_h_reg;
            mag_v3_reg <= mag_v_reg;
            neg_h3_reg <= neg_h_reg;
            neg_v3_reg <= neg_v_reg;

            p_reg <= p_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign p         = p_reg;

endmodule

FILE: rtl/crd_rot.sv
module crd_rot
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  crd_pkg::pvec_t  p,
    input  crd_pkg::quat_t  quat,
    output logic            out_valid,
    output crd_pkg::rmag_t  mag,
    output logic [2:0]      neg
);

    logic [4:0] vld_reg;

    logic signed [15:0] qw;
    logic signed [15:0] qc [3];
    logic signed [16:0] w2;

    logic signed [31:0] sq_reg  [4];
    logic signed [44:0] dot_reg [3];
    logic signed [44:0] cra_reg [3];
    logic signed [44:0] crb_reg [3];
    crd_pkg::pvec_t     p1_reg, p2_reg;

    logic signed [33:0] k1_reg;
    logic signed [47:0] d2_reg;
    logic signed [45:0] c_reg [3];

    logic signed [62:0] mk_reg [3];
    logic signed [63:0] md_reg [3];
    logic signed [62:0] mw_reg [3];

    logic signed [crd_pkg::R_W-1:0] r_reg [3];
    crd_pkg::rmag_t mag_reg;
    logic [2:0]     neg_reg;

    assign qw    = $signed(quat.w);
    assign qc[0] = $signed(quat.x);
    assign qc[1] = $signed(quat.y);
    assign qc[2] = $signed(quat.z);
    assign w2    = $signed({quat.w, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // r = (w^2 - |q|^2) p + 2 (q.p) q + 2 w (q x p)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0]  <= qw * qw;
            sq_reg[1]  <= qc[0] * qc[0];
            sq_reg[2]  <= qc[1] * qc[1];
            sq_reg[3]  <= qc[2] * qc[2];
            dot_reg[0] <= qc[0] * $signed(p[0]);
            dot_reg[1] <= qc[1] * $signed(p[1]);
            dot_reg[2] <= qc[2] * $signed(p[2]);
            cra_reg[0] <= qc[1] * $signed(p[2]);
            crb_reg[0] <= qc[2] * $signed(p[1]);
            cra_reg[1] <= qc[2] * $signed(p[0]);
            crb_reg[1] <= qc[0] * $signed(p[2]);
            cra_reg[2] <= qc[0] * $signed(p[1]);
            crb_reg[2] <= qc[1] * $signed(p[0]);
            p1_reg     <= p;

            k1_reg <= sq_reg[0] - (sq_reg[1] + sq_reg[2] + sq_reg[3]);
            d2_reg <= (dot_reg[0] + dot_reg[1] + dot_reg[2]) <<< 1;
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= cra_reg[i] - crb_reg[i];
            end
            p2_reg <= p1_reg;

            for (int i = 0; i < 3; i++)
            begin
                mk_reg[i] <= k1_reg * $signed(p2_reg[i]);
                md_reg[i] <= d2_reg * qc[i];
                mw_reg[i] <= w2 * c_reg[i];
            end

            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= mk_reg[i] + md_reg[i] + mw_reg[i];
            end

            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= r_reg[i][crd_pkg::R_W-1];
                mag_reg[i] <= r_reg[i][crd_pkg::R_W-1] ? crd_pkg::RM_W'(-r_reg[i])
                                                       : crd_pkg::RM_W'(r_reg[i]);
            end
        end
    end

    assign out_valid = vld_reg[4];
    assign mag       = mag_reg;
    assign neg       = neg_reg;

endmodule

FILE: rtl/crd_norm.sv
module crd_norm
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  crd_pkg::rmag_t              mag,
    input  logic [2:0]                  neg,
    output logic                        out_valid,
    output crd_pkg::norm_t              nrm,
    output logic [crd_pkg::SQ_W-1:0]    sumsq
);

    localparam int MW = crd_pkg::RM_W;
    localparam int NW = crd_pkg::N_W;

    logic [4:0] vld_reg;

    logic [MW-1:0]  orv_reg;
    crd_pkg::rmag_t m1_reg, m2_reg;
    logic [2:0]     n1_reg, n2_reg;

    logic [6:0] msb;
    logic [6:0] msb_reg;
    logic       zero_reg;

    logic [MW-1:0]  sh [3];
    crd_pkg::norm_t nrm_next, nrm3_reg, nrm4_reg, nrm5_reg;

    logic [2*NW-1:0]            sq_reg [3];
    logic [crd_pkg::SQ_W-1:0]   sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orv_reg[i])
            begin
                msb = 7'(i);
            end
        end
    end

    // move the leading one of the largest magnitude to bit 29
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (msb_reg >= 7'(crd_pkg::N_TOP))
            begin
                sh[i] = m2_reg[i] >> (msb_reg - 7'(crd_pkg::N_TOP));
            end
            else
            begin
                sh[i] = m2_reg[i] << (7'(crd_pkg::N_TOP) - msb_reg);
            end
            nrm_next.mag[i] = sh[i][NW-1:0];
        end
        nrm_next.neg  = n2_reg;
        nrm_next.zero = zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            orv_reg <= mag[0] | mag[1] | mag[2];
            m1_reg  <= mag;
            n1_reg  <= neg;

            msb_reg  <= msb;
            zero_reg <= (orv_reg == '0);
            m2_reg   <= m1_reg;
            n2_reg   <= n1_reg;

            nrm3_reg <= nrm_next;

            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= nrm3_reg.mag[i] * nrm3_reg.mag[i];
            end
            nrm4_reg <= nrm3_reg;

            sum_reg  <= crd_pkg::SQ_W'(sq_reg[0]) + crd_pkg::SQ_W'(sq_reg[1])
                        + crd_pkg::SQ_W'(sq_reg[2]);
            nrm5_reg <= nrm4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign nrm       = nrm5_reg;
    assign sumsq     = sum_reg;

endmodule

FILE: rtl/crd_sqrt.sv
module crd_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  crd_pkg::norm_t              nrm,
    input  logic [crd_pkg::SQ_W-1:0]    sumsq,
    output logic                        out_valid,
    output crd_pkg::norm_t              nrm_out,
    output logic [crd_pkg::ROOT_W-1:0]  root
);

    localparam int SW = crd_pkg::SQ_W;
    localparam int RW = crd_pkg::ROOT_W;

    logic [RW-1:0]  vld_reg;
    logic [SW-1:0]  rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    crd_pkg::norm_t pay_reg  [RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[RW-2:0], in_valid};
        end
    end

    // one root bit per stage, most significant first
    for (genvar g = 0; g < RW; g++)
    begin : g_step
        localparam int B = RW - 1 - g;

        logic [SW-1:0]  rem_in;
        logic [RW-1:0]  root_in;
        crd_pkg::norm_t pay_in;
        logic [SW:0]    trial;

        if (g == 0)
        begin : g_first
            assign rem_in  = sumsq;
            assign root_in = '0;
            assign pay_in  = nrm;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign pay_in  = pay_reg[g-1];
        end

        assign trial = ((SW + 1)'(root_in) << (B + 1)) | ((SW + 1)'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[g]  <= rem_in - trial[SW-1:0];
                    root_reg[g] <= root_in | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[g]  <= rem_in;
                    root_reg[g] <= root_in;
                end
                pay_reg[g] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign nrm_out   = pay_reg[RW-1];
    assign root      = root_reg[RW-1];

endmodule

FILE: rtl/crd_div.sv
module crd_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  crd_pkg::norm_t                      nrm,
    input  logic [crd_pkg::ROOT_W-1:0]          len,
    output logic                                out_valid,
    output logic [2:0][crd_pkg::DQ_W-1:0]       quo,
    output logic [2:0]                          neg,
    output logic                                zero
);

    localparam int QW = crd_pkg::DQ_W;
    localparam int NW = crd_pkg::NUM_W;
    localparam int DW = crd_pkg::DEN_W;

    logic [QW:0] vld_reg;

    // entry stage: numerator m*2^16 + len, divisor 2*len
    logic [NW-1:0] num0_reg [3];
    logic [DW-1:0] den0_reg;
    logic [2:0]    neg0_reg;
    logic          zero0_reg;

    logic [NW-1:0] rem_reg  [QW][3];
    logic [QW-1:0] q_reg    [QW][3];
    logic [DW-1:0] den_reg  [QW];
    logic [2:0]    neg_reg  [QW];
    logic          zero_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num0_reg[i] <= NW'({nrm.mag[i], QW'(0)}) + NW'(len);
            end
            den0_reg  <= {len, 1'b0};
            neg0_reg  <= nrm.neg;
            zero0_reg <= nrm.zero;
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_step
        localparam int B = QW - 1 - g;

        logic [NW-1:0] rem_in [3];
        logic [QW-1:0] q_in   [3];
        logic [DW-1:0] den_in;
        logic [2:0]    neg_in;
        logic          zero_in;
        logic [NW-1:0] dsh;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = num0_reg[i];
                    q_in[i]   = '0;
                end
            end
            assign den_in  = den0_reg;
            assign neg_in  = neg0_reg;
            assign zero_in = zero0_reg;
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = rem_reg[g-1][i];
                    q_in[i]   = q_reg[g-1][i];
                end
            end
            assign den_in  = den_reg[g-1];
            assign neg_in  = neg_reg[g-1];
            assign zero_in = zero_reg[g-1];
        end

        assign dsh = NW'(den_in) << B;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_in[i] >= dsh)
                    begin
                        rem_reg[g][i] <= rem_in[i] - dsh;
                        q_reg[g][i]   <= q_in[i] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[g][i] <= rem_in[i];
                        q_reg[g][i]   <= q_in[i];
                    end
                end
                den_reg[g]  <= den_in;
                neg_reg[g]  <= neg_in;
                zero_reg[g] <= zero_in;
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo[0]    = q_reg[QW-1][0];
    assign quo[1]    = q_reg[QW-1][1];
    assign quo[2]    = q_reg[QW-1][2];
    assign neg       = neg_reg[QW-1];
    assign zero      = zero_reg[QW-1];

endmodule

FILE: rtl/camera_ray_direction_gen.sv
// Channel   Direction  Transfer when          Payload
// s_*       in         s_tvalid & s_tready    pixel_column, pixel_row
// m_*       out        m_tvalid & m_tready    dir_x, dir_y, dir_z
// cfg_*     in         cfg_valid & cfg_ready  register index, write data
//
// One pixel per clock unless the output stalls; stages in order: mapping, rotation,
// normalisation, square root, division and the output register.
// The square root stage, one root bit per stage, sets the depth.
// rst_n clears all valid bits and loads the register reset values; data regs are not reset.
// A stall holds every stage; s_tready stays high while a single result waits.
module camera_ray_direction_gen
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // pixel_column[11:0], pixel_row[23:12]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DW = crd_pkg::DIR_W;

    crd_pkg::quat_t quat_reg;
    crd_pkg::view_t view_reg;

    logic adv;

    logic           map_valid;
    crd_pkg::pvec_t map_p;
    logic           rot_valid;
    crd_pkg::rmag_t rot_mag;
    logic [2:0]     rot_neg;
    logic           norm_valid;
    crd_pkg::norm_t norm_nrm;
    logic [crd_pkg::SQ_W-1:0] norm_sum;
    logic           sqrt_valid;
    crd_pkg::norm_t sqrt_nrm;
    logic [crd_pkg::ROOT_W-1:0] sqrt_root;
    logic           div_valid;
    logic [2:0][DW-1:0] div_quo;
    logic [2:0]     div_neg;
    logic           div_zero;

    logic [2:0][DW-1:0] dir;
    logic [3*DW-1:0]    res;
    logic [3*DW-1:0]    out_reg, skid_reg;
    logic               out_v_reg, skid_v_reg;
    logic               push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w            <= 16'h7FFF;
            quat_reg.x            <= '0;
            quat_reg.y            <= '0;
            quat_reg.z            <= '0;
            view_reg.plane_width  <= 16'h2000;
            view_reg.plane_height <= 16'h2000;
            view_reg.step_h       <= '0;
            view_reg.step_v       <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                crd_pkg::REG_QUAT_W:       quat_reg.w <= cfg_data[15:0];
                crd_pkg::REG_QUAT_X:       quat_reg.x <= cfg_data[15:0];
                crd_pkg::REG_QUAT_Y:       quat_reg.y <= cfg_data[15:0];
                crd_pkg::REG_QUAT_Z:       quat_reg.z <= cfg_data[15:0];
                crd_pkg::REG_PLANE_WIDTH:  view_reg.plane_width  <= cfg_data[15:0];
                crd_pkg::REG_PLANE_HEIGHT: view_reg.plane_height <= cfg_data[15:0];
                crd_pkg::REG_STEP_H:       view_reg.step_h <= cfg_data;
                crd_pkg::REG_STEP_V:       view_reg.step_v <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // the whole pipeline advances unless the skid slot is occupied
    assign adv      = ~skid_v_reg;
    assign s_tready = adv;

    crd_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .col       (s_tdata[11:0]),
        .row       (s_tdata[23:12]),
        .view      (view_reg),
        .out_valid (map_valid),
        .p         (map_p)
    );

    crd_rot u_rot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (map_valid),
        .p         (map_p),
        .quat      (quat_reg),
        .out_valid (rot_valid),
        .mag       (rot_mag),
        .neg       (rot_neg)
    );

    crd_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rot_valid),
        .mag       (rot_mag),
        .neg       (rot_neg),
        .out_valid (norm_valid),
        .nrm       (norm_nrm),
        .sumsq     (norm_sum)
    );

    crd_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (norm_valid),
        .nrm       (norm_nrm),
        .sumsq     (norm_sum),
        .out_valid (sqrt_valid),
        .nrm_out   (sqrt_nrm),
        .root      (sqrt_root)
    );

    crd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sqrt_valid),
        .nrm       (sqrt_nrm),
        .len       (sqrt_root),
        .out_valid (div_valid),
        .quo       (div_quo),
        .neg       (div_neg),
        .zero      (div_zero)
    );

    // apply sign; the zero flag clears all, and a positive full-scale quotient saturates
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_zero)
            begin
                dir[i] = '0;
            end
            else if (div_neg[i])
            begin
                dir[i] = DW'(-div_quo[i]);
            end
            else if (div_quo[i][DW-1])
            begin
                dir[i] = {1'b0, {(DW-1){1'b1}}};
            end
            else
            begin
                dir[i] = div_quo[i];
            end
        end
        res = {dir[2], dir[1], dir[0]};
    end

    assign push = adv & div_valid;
    assign pop  = out_v_reg & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (skid_v_reg)
            begin
                if (pop)
                begin
                    skid_v_reg <= 1'b0;
                end
            end
            else if (push & out_v_reg & ~pop)
            begin
                skid_v_reg <= 1'b1;
            end
            out_v_reg <= skid_v_reg | push | (out_v_reg & ~pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (~out_v_reg | pop)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: rtl/crd_checker.sv
module crd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [47:0]                      m_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // reset empties the output side by the next edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // input stalls only while a result is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind camera_ray_direction_gen crd_checker u_crd_checker (.*);

FILE: test/camera_ray_direction_gen_checker.sv
`timescale 1ns / 1ps

module camera_ray_direction_gen_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel_column[11:0], pixel_row[23:12]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [47:0]                    m_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [crd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             outstanding
);

    logic [crd_pkg::QUAT_W-1:0]  qw, qx, qy, qz;
    logic [crd_pkg::PLANE_W-1:0] plane_w, plane_h;
    logic [crd_pkg::STEP_W-1:0]  step_h, step_v;
    logic [47:0]                 dir_q[$];

    function automatic logic [63:0] max_of(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [63:0] r;
        r = a;
        if (b > r) r = b;
        if (c > r) r = c;
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [47:0] ray_direction(logic [11:0] col, logic [11:0] row);
        logic [63:0] m[3];
        bit          ng[3];
        longint      p[3];
        longint      r[3];
        longint      w, x, y, z, k1, d2, cx, cy, cz, t;
        logic [63:0] len, q;
        logic [15:0] s;
        logic [47:0] res;
        m[0]  = 64'd1 << 28;
        ng[0] = 0;
        t     = longint'({52'd0, col}) * longint'({32'd0, step_h}) - (longint'({48'd0, plane_w}) << 15);
        ng[1] = t < 0;
        m[1]  = ng[1] ? -t : t;
        t     = longint'({52'd0, row}) * longint'({32'd0, step_v}) - (longint'({48'd0, plane_h}) << 15);
        ng[2] = t < 0;
        m[2]  = ng[2] ? -t : t;
        while (max_of(m[0], m[1], m[2]) >= (64'd1 << 28))
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        for (int i = 0; i < 3; i++) p[i] = ng[i] ? -longint'(m[i]) : longint'(m[i]);
        w  = longint'($signed(qw));
        x  = longint'($signed(qx));
        y  = longint'($signed(qy));
        z  = longint'($signed(qz));
        k1 = w * w - (x * x + y * y + z * z);
        d2 = 2 * (x * p[0] + y * p[1] + z * p[2]);
        cx = y * p[2] - z * p[1];
        cy = z * p[0] - x * p[2];
        cz = x * p[1] - y * p[0];
        r[0] = k1 * p[0] + d2 * x + 2 * w * cx;
        r[1] = k1 * p[1] + d2 * y + 2 * w * cy;
        r[2] = k1 * p[2] + d2 * z + 2 * w * cz;
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = r[i] < 0;
            m[i]  = ng[i] ? -r[i] : r[i];
        end
        if (max_of(m[0], m[1], m[2]) == 0) return '0;
        while (max_of(m[0], m[1], m[2]) >= (64'd1 << 30))
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        while (max_of(m[0], m[1], m[2]) < (64'd1 << 29))
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 16) + len) / (len << 1);
            // full scale only fits on the negative side
            if (!ng[i] && q > 64'd32767) q = 64'd32767;
            if (ng[i] && q > 64'd32768) q = 64'd32768;
            s = ng[i] ? -q[15:0] : q[15:0];
            res[16*i +: 16] = s;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s expected %0d got %0d", $realtime, what, $signed(want), $signed(got));
        errors++;
    endtask

    initial errors = 0;
    assign outstanding = dir_q.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw      <= 16'd32767;
            qx      <= '0;
            qy      <= '0;
            qz      <= '0;
            plane_w <= 16'd8192;
            plane_h <= 16'd8192;
            step_h  <= '0;
            step_v  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crd_pkg::REG_QUAT_W:       qw      <= cfg_data[15:0];
                crd_pkg::REG_QUAT_X:       qx      <= cfg_data[15:0];
                crd_pkg::REG_QUAT_Y:       qy      <= cfg_data[15:0];
                crd_pkg::REG_QUAT_Z:       qz      <= cfg_data[15:0];
                crd_pkg::REG_PLANE_WIDTH:  plane_w <= cfg_data[15:0];
                crd_pkg::REG_PLANE_HEIGHT: plane_h <= cfg_data[15:0];
                crd_pkg::REG_STEP_H:       step_h  <= cfg_data;
                crd_pkg::REG_STEP_V:       step_v  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        logic [47:0] want;
        if (rst_n && s_tvalid && s_tready)
            dir_q.push_back(ray_direction(s_tdata[11:0], s_tdata[23:12]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dir_q.size() == 0)
            begin
                $display("%0t: unexpected direction transfer %h", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                want = dir_q.pop_front();
                if (want[15:0] !== m_tdata[15:0]) report_mismatch("dir_x", want[15:0], m_tdata[15:0]);
                if (want[31:16] !== m_tdata[31:16])
                    report_mismatch("dir_y", want[31:16], m_tdata[31:16]);
                if (want[47:32] !== m_tdata[47:32])
                    report_mismatch("dir_z", want[47:32], m_tdata[47:32]);
            end
        end
    end

endmodule

FILE: test/camera_ray_direction_gen_tb.sv
`timescale 1ns / 1ps

module camera_ray_direction_gen_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN       = 100;

    logic                           clk = 0;
    logic                           rst_n = 0;
    logic                           s_tvalid = 0;
    logic                           s_tready;
    logic [23:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 0;
    logic [47:0]                    m_tdata;
    logic                           cfg_valid = 0;
    logic                           cfg_ready;
    logic [crd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [crd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int          errors;
    int          outstanding;
    int          cycles = 0;
    int          idle_mode = 0;
    bit          hold_sink = 0;
    bit          squeeze = 0;
    logic [23:0] pixel_q[$];

    camera_ray_direction_gen uut (.*);

    camera_ray_direction_gen_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("camera_ray_direction_gen: mismatch");
            $finish;
        end
    end

    // pixel source: hold the item until its transfer, then maybe idle
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            if (s_tvalid) void'(pixel_q.pop_front());
            if (pixel_q.size() != 0 && !((idle_mode == 1 && $urandom_range(99) < 55) ||
                                          (idle_mode == 3 && $urandom_range(99) < 16)))
            begin
                s_tvalid <= 1;
                s_tdata  <= pixel_q[0];
            end
            else
                s_tvalid <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !hold_sink && !((idle_mode == 2 && $urandom_range(99) < 55) ||
                                        (idle_mode == 3 && $urandom_range(99) < 16));
    end

    // long sink hold-off so the pipeline fills and back-pressures the source
    initial
    begin
        wait (squeeze);
        @(posedge clk);
        hold_sink <= 1;
        repeat (400) @(posedge clk);
        hold_sink <= 0;
    end

    task automatic cfg_write(crd_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic cfg_view(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [15:0] pw, logic [15:0] ph, logic [31:0] sh, logic [31:0] sv);
        cfg_write(crd_pkg::REG_QUAT_W, {16'd0, w});
        cfg_write(crd_pkg::REG_QUAT_X, {16'd0, x});
        cfg_write(crd_pkg::REG_QUAT_Y, {16'd0, y});
        cfg_write(crd_pkg::REG_QUAT_Z, {16'd0, z});
        cfg_write(crd_pkg::REG_PLANE_WIDTH, {16'd0, pw});
        cfg_write(crd_pkg::REG_PLANE_HEIGHT, {16'd0, ph});
        cfg_write(crd_pkg::REG_STEP_H, sh);
        cfg_write(crd_pkg::REG_STEP_V, sv);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid || outstanding != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_view();
        logic [15:0] pw, ph;
        logic [31:0] sh, sv;
        int          cols, rows;
        pw   = $urandom_range(99) < 80 ? 16'($urandom_range(16384)) : 16'($urandom);
        ph   = $urandom_range(99) < 80 ? 16'($urandom_range(16384)) : 16'($urandom);
        cols = int'($urandom_range(4096, 1));
        rows = int'($urandom_range(4096, 1));
        sh   = $urandom_range(99) < 80 ? 32'((longint'(pw) << 16) / cols) : $urandom;
        sv   = $urandom_range(99) < 80 ? 32'((longint'(ph) << 16) / rows) : $urandom;
        if ($urandom_range(99) < 60)
            cfg_view(16'($urandom_range(32767, 20000)), 16'($urandom_range(12000) - 6000),
                     16'($urandom_range(12000) - 6000), 16'($urandom_range(12000) - 6000),
                     pw, ph, sh, sv);
        else
            cfg_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     pw, ph, sh, sv);
    endtask

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back($urandom_range(99) < 70 ? {12'($urandom_range(1023)),
                              12'($urandom_range(1023))} : 24'($urandom));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset view: zero steps put both offsets at minus half the plane
        pixel_q.push_back({12'd0, 12'd0});
        pixel_q.push_back({12'd4095, 12'd4095});
        drain();

        // non-default plane and steps; corners and centre pixel
        cfg_view(16'd32767, 16'd0, 16'd0, 16'd0, 16'd8192, 16'd4096, 32'd1 << 18, 32'd1 << 17);
        pixel_q.push_back({12'd0, 12'd0});
        pixel_q.push_back({12'd0, 12'd4095});
        pixel_q.push_back({12'd4095, 12'd0});
        pixel_q.push_back({12'd2048, 12'd2048});
        pixel_q.push_back({12'd4095, 12'd4095});
        drain();

        // half turn about z: full-scale negative x
        cfg_view(16'd0, 16'd0, 16'd0, 16'd32767, 16'd0, 16'd0, 32'd0, 32'd0);
        pixel_q.push_back({12'd100, 12'd7});
        drain();

        // zero quaternion gives a zero vector; out-of-range index is dropped
        cfg_view(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        cfg_write(crd_pkg::reg_idx_t'(8'd8), 32'h1234);
        cfg_write(crd_pkg::reg_idx_t'(8'd255), 32'h5678);
        cfg_valid <= 0;
        pixel_q.push_back({12'd0, 12'd0});
        pixel_q.push_back({12'd4095, 12'd4095});
        drain();

        // extreme and non-unit quaternions, huge steps
        cfg_view(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'd0);
        pixel_q.push_back({12'd0, 12'd4095});
        pixel_q.push_back({12'd4095, 12'd0});
        pixel_q.push_back({12'd1, 12'd1});
        drain();
        cfg_view(16'd1000, 16'd3, 16'hFFF0, 16'd200, 16'd0, 16'hFFFF, 32'd0, 32'hFFFFFFFF);
        pixel_q.push_back({12'd4095, 12'd4095});
        pixel_q.push_back({12'd0, 12'd0});
        pixel_q.push_back({12'hAAA, 12'h555});
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_mode = ph % 4;
            random_view();
            random_pixels(120);
            drain();
        end

        idle_mode = 0;
        random_view();
        random_pixels(100);
        squeeze = 1;
        drain();

        if (errors == 0)
            $display("camera_ray_direction_gen: match");
        else
            $display("camera_ray_direction_gen: mismatch");
        $finish;
    end

endmodule

FILE: camera_ray_direction_gen.f
rtl/crd_pkg.sv
rtl/crd_map.sv
rtl/crd_rot.sv
rtl/crd_norm.sv
rtl/crd_sqrt.sv
rtl/crd_div.sv
rtl/camera_ray_direction_gen.sv
rtl/crd_checker.sv
test/camera_ray_direction_gen_checker.sv
test/camera_ray_direction_gen_tb.sv
